// ===== rtl/saabb_pkg.sv =====
// shared constants and types for the swept box intersection block
`default_nettype none
package saabb_pkg;
  localparam int COORD_BITS_DEF     = 32;
  localparam int TIME_FRAC_BITS_DEF = 16;
  localparam int EPS_W              = 16;
  localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;
  localparam int CFG_ADDR_W         = 3;
  localparam int CFG_DATA_W         = 32;
  localparam int NUM_LANES          = 4;
  localparam int LANE_XF            = 0;
  localparam int LANE_XL            = 1;
  localparam int LANE_YF            = 2;
  localparam int LANE_YL            = 3;

  typedef enum logic [0:0] {
    REG_MOTION_EPSILON = 1'b0
  } reg_idx_t;

  typedef struct packed {
    logic                 overlap;
    logic                 miss;
    logic [NUM_LANES-1:0] en;
  } ctl_t;
endpackage
`default_nettype wire

// ===== rtl/swept_aabb_intersection_time.sv =====
// swept box intersection top level: register port, prep, divider chain, resolve
// Tests moving box B against box A over one time step, one pair per word.
// Input channel in_valid/in_ready carries both boxes and both velocities;
// output channel out_valid/out_ready carries hit, time_first and time_last.
// Throughput: one word per cycle while the receiver keeps up. Each word passes
// through the input stage, the chain of divider cells, one quotient bit
// per cell for all four axis times at once, and the output stage.
// The whole pipeline advances only when the output register is empty or
// being taken, so a stalled receiver holds every stage and drops in_ready;
// no word is lost or repeated.
// The APB-style port holds motion_epsilon at byte address 0; write it only
// while the block is empty.
// Synchronous reset clears all valid flags and sets motion_epsilon to 1;
// no clearing pass is needed.
// Times are Q1.16 in [0,1]; a miss returns hit 0 with both times 0, boxes
// already touching return hit 1 at times 0,0.
`default_nettype none
module swept_aabb_intersection_time #(
  parameter int COORD_BITS     = saabb_pkg::COORD_BITS_DEF,
  parameter int TIME_FRAC_BITS = saabb_pkg::TIME_FRAC_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [COORD_BITS-1:0]            in_a_min_x,
  input  wire logic [COORD_BITS-1:0]            in_a_min_y,
  input  wire logic [COORD_BITS-1:0]            in_a_max_x,
  input  wire logic [COORD_BITS-1:0]            in_a_max_y,
  input  wire logic [COORD_BITS-1:0]            in_b_min_x,
  input  wire logic [COORD_BITS-1:0]            in_b_min_y,
  input  wire logic [COORD_BITS-1:0]            in_b_max_x,
  input  wire logic [COORD_BITS-1:0]            in_b_max_y,
  input  wire logic [COORD_BITS-1:0]            in_vel_a_x,
  input  wire logic [COORD_BITS-1:0]            in_vel_a_y,
  input  wire logic [COORD_BITS-1:0]            in_vel_b_x,
  input  wire logic [COORD_BITS-1:0]            in_vel_b_y,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_hit,
  output logic [TIME_FRAC_BITS:0]               out_time_first,
  output logic [TIME_FRAC_BITS:0]               out_time_last,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [saabb_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [saabb_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [saabb_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                  pready
);
  localparam int W  = COORD_BITS + 1;
  localparam int QW = TIME_FRAC_BITS + 1;
  localparam int NC = TIME_FRAC_BITS + 1;
  localparam int NL = saabb_pkg::NUM_LANES;
  localparam logic [QW:0] T_ONE = (QW+1)'(1) << TIME_FRAC_BITS;

  logic [saabb_pkg::EPS_W-1:0] eps_r;
  logic                        adv;

  logic                              vld_c [NC+1];
  saabb_pkg::ctl_t                   ctl_c [NC+1];
  logic [NL-1:0][W-1:0]              rem_c [NC+1];
  logic [NL-1:0][W-1:0]              den_c [NC+1];
  logic [NL-1:0][QW-1:0]             quo_c [NC+1];
  logic [NL-1:0]                     sat_c [NC+1];

  // register port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= saabb_pkg::EPS_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[saabb_pkg::CFG_ADDR_W-1] == saabb_pkg::REG_MOTION_EPSILON) begin
      eps_r <= pwdata[saabb_pkg::EPS_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[saabb_pkg::CFG_ADDR_W-1] == saabb_pkg::REG_MOTION_EPSILON) ?
                  saabb_pkg::CFG_DATA_W'(eps_r) : '0;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  saabb_prep #(.CW(COORD_BITS)) u_prep (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .vld_i  (in_valid),
    .amin_i ({in_a_min_y, in_a_min_x}),
    .amax_i ({in_a_max_y, in_a_max_x}),
    .bmin_i ({in_b_min_y, in_b_min_x}),
    .bmax_i ({in_b_max_y, in_b_max_x}),
    .va_i   ({in_vel_a_y, in_vel_a_x}),
    .vb_i   ({in_vel_b_y, in_vel_b_x}),
    .eps_i  (eps_r),
    .vld_o  (vld_c[0]),
    .ctl_o  (ctl_c[0]),
    .num_o  (rem_c[0]),
    .den_o  (den_c[0]),
    .sat_o  (sat_c[0])
  );

  assign quo_c[0] = '0;

  for (genvar g = 0; g < NC; g++) begin : g_cell
    saabb_div_cell #(.W(W), .QW(QW), .FIRST(g == 0)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .vld_i (vld_c[g]),
      .ctl_i (ctl_c[g]),
      .rem_i (rem_c[g]),
      .den_i (den_c[g]),
      .quo_i (quo_c[g]),
      .sat_i (sat_c[g]),
      .vld_o (vld_c[g+1]),
      .ctl_o (ctl_c[g+1]),
      .rem_o (rem_c[g+1]),
      .den_o (den_c[g+1]),
      .quo_o (quo_c[g+1]),
      .sat_o (sat_c[g+1])
    );
  end

  saabb_resolve #(.TF(TIME_FRAC_BITS)) u_resolve (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .vld_i (vld_c[NC]),
    .ctl_i (ctl_c[NC]),
    .quo_i (quo_c[NC]),
    .sat_i (sat_c[NC]),
    .vld_o (out_valid),
    .hit_o (out_hit),
    .tf_o  (out_time_first),
    .tl_o  (out_time_last)
  );

  // remainders and divisors leave the last cell unused
  logic unused_tail;
  assign unused_tail = ^{rem_c[NC], den_c[NC]};

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_time_first == '0 && out_time_last == '0)
    else $error("miss with nonzero times");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_time_first <= out_time_last)
    else $error("first contact after last contact");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> {1'b0, out_time_last} <= T_ONE)
    else $error("contact time beyond one step");
endmodule
`default_nettype wire

// ===== rtl/saabb_prep.sv =====
// input stage: relative motion, per-axis tests and divider operands
`default_nettype none
module saabb_prep #(
  parameter int CW = saabb_pkg::COORD_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              adv,
  input  wire logic                              vld_i,
  input  wire logic [1:0][CW-1:0]                amin_i,
  input  wire logic [1:0][CW-1:0]                amax_i,
  input  wire logic [1:0][CW-1:0]                bmin_i,
  input  wire logic [1:0][CW-1:0]                bmax_i,
  input  wire logic [1:0][CW-1:0]                va_i,
  input  wire logic [1:0][CW-1:0]                vb_i,
  input  wire logic [saabb_pkg::EPS_W-1:0]       eps_i,
  output logic                                   vld_o,
  output saabb_pkg::ctl_t                        ctl_o,
  output logic [saabb_pkg::NUM_LANES-1:0][CW:0]  num_o,
  output logic [saabb_pkg::NUM_LANES-1:0][CW:0]  den_o,
  output logic [saabb_pkg::NUM_LANES-1:0]        sat_o
);
  localparam int W = CW + 1;

  logic signed [W-1:0] amin [2];
  logic signed [W-1:0] amax [2];
  logic signed [W-1:0] bmin [2];
  logic signed [W-1:0] bmax [2];
  logic signed [W-1:0] v    [2];
  logic [W-1:0]        vmag [2];
  logic [1:0]          still, neg, pos, ovl, miss_ax;
  logic [saabb_pkg::NUM_LANES-1:0]        en_nxt, sat_nxt;
  logic [saabb_pkg::NUM_LANES-1:0][W-1:0] num_nxt, den_nxt;
  saabb_pkg::ctl_t     ctl_nxt;
  logic                vld_r;
  saabb_pkg::ctl_t     ctl_r;
  logic [saabb_pkg::NUM_LANES-1:0][W-1:0] num_r, den_r;
  logic [saabb_pkg::NUM_LANES-1:0]        sat_r;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      amin[i] = W'(signed'(amin_i[i]));
      amax[i] = W'(signed'(amax_i[i]));
      bmin[i] = W'(signed'(bmin_i[i]));
      bmax[i] = W'(signed'(bmax_i[i]));
      v[i]    = W'(signed'(vb_i[i])) - W'(signed'(va_i[i]));
      neg[i]  = v[i][W-1];
      pos[i]  = !v[i][W-1] && (v[i] != '0);
      vmag[i] = neg[i] ? W'(-v[i]) : W'(v[i]);
      still[i] = vmag[i] < W'(eps_i);
      ovl[i]  = (bmax[i] >= amin[i]) && (bmin[i] <= amax[i]);
      if (still[i]) begin
        miss_ax[i] = !ovl[i];
      end else if (neg[i]) begin
        miss_ax[i] = bmax[i] < amin[i];
      end else begin
        miss_ax[i] = pos[i] && (bmin[i] > amax[i]);
      end
      en_nxt[2*i]   = !still[i] && (neg[i] ? (amax[i] <= bmin[i]) :
                                     (pos[i] && (bmax[i] <= amin[i])));
      en_nxt[2*i+1] = !still[i] && (neg[i] ? (bmax[i] >= amin[i]) :
                                     (pos[i] && (amax[i] >= bmin[i])));
      num_nxt[2*i]   = neg[i] ? W'(bmin[i] - amax[i]) : W'(amin[i] - bmax[i]);
      num_nxt[2*i+1] = neg[i] ? W'(bmax[i] - amin[i]) : W'(amax[i] - bmin[i]);
      den_nxt[2*i]   = vmag[i];
      den_nxt[2*i+1] = vmag[i];
    end
    for (int k = 0; k < saabb_pkg::NUM_LANES; k++) begin
      sat_nxt[k] = {1'b0, num_nxt[k]} >= {den_nxt[k], 1'b0};
    end
    ctl_nxt.overlap = ovl[0] && ovl[1];
    ctl_nxt.miss    = (still[0] && still[1]) || miss_ax[0] || miss_ax[1];
    ctl_nxt.en      = en_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_r <= ctl_nxt;
      num_r <= num_nxt;
      den_r <= den_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign vld_o = vld_r;
  assign ctl_o = ctl_r;
  assign num_o = num_r;
  assign den_o = den_r;
  assign sat_o = sat_r;
endmodule
`default_nettype wire

// ===== rtl/saabb_div_cell.sv =====
// one quotient bit of the four restoring dividers, registered
`default_nettype none
module saabb_div_cell #(
  parameter int W     = saabb_pkg::COORD_BITS_DEF + 1,
  parameter int QW    = saabb_pkg::TIME_FRAC_BITS_DEF + 1,
  parameter bit FIRST = 1'b0
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                adv,
  input  wire logic                                vld_i,
  input  wire saabb_pkg::ctl_t                     ctl_i,
  input  wire logic [saabb_pkg::NUM_LANES-1:0][W-1:0]  rem_i,
  input  wire logic [saabb_pkg::NUM_LANES-1:0][W-1:0]  den_i,
  input  wire logic [saabb_pkg::NUM_LANES-1:0][QW-1:0] quo_i,
  input  wire logic [saabb_pkg::NUM_LANES-1:0]         sat_i,
  output logic                                     vld_o,
  output saabb_pkg::ctl_t                          ctl_o,
  output logic [saabb_pkg::NUM_LANES-1:0][W-1:0]   rem_o,
  output logic [saabb_pkg::NUM_LANES-1:0][W-1:0]   den_o,
  output logic [saabb_pkg::NUM_LANES-1:0][QW-1:0]  quo_o,
  output logic [saabb_pkg::NUM_LANES-1:0]          sat_o
);
  logic [saabb_pkg::NUM_LANES-1:0][W:0]    trial;
  logic [saabb_pkg::NUM_LANES-1:0]         ge;
  logic [saabb_pkg::NUM_LANES-1:0][W-1:0]  rem_nxt;
  logic [saabb_pkg::NUM_LANES-1:0][QW-1:0] quo_nxt;
  logic                                    vld_r;
  saabb_pkg::ctl_t                         ctl_r;
  logic [saabb_pkg::NUM_LANES-1:0][W-1:0]  rem_r, den_r;
  logic [saabb_pkg::NUM_LANES-1:0][QW-1:0] quo_r;
  logic [saabb_pkg::NUM_LANES-1:0]         sat_r;

  always_comb begin
    for (int k = 0; k < saabb_pkg::NUM_LANES; k++) begin
      trial[k]   = FIRST ? {1'b0, rem_i[k]} : {rem_i[k], 1'b0};
      ge[k]      = trial[k] >= {1'b0, den_i[k]};
      rem_nxt[k] = ge[k] ? W'(trial[k] - {1'b0, den_i[k]}) : W'(trial[k]);
      quo_nxt[k] = {quo_i[k][QW-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_r <= ctl_i;
      rem_r <= rem_nxt;
      den_r <= den_i;
      quo_r <= quo_nxt;
      sat_r <= sat_i;
    end
  end

  assign vld_o = vld_r;
  assign ctl_o = ctl_r;
  assign rem_o = rem_r;
  assign den_o = den_r;
  assign quo_o = quo_r;
  assign sat_o = sat_r;
endmodule
`default_nettype wire

// ===== rtl/saabb_resolve.sv =====
// folds the per-axis times into first and last contact, output register
`default_nettype none
module saabb_resolve #(
  parameter int TF = saabb_pkg::TIME_FRAC_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 adv,
  input  wire logic                                 vld_i,
  input  wire saabb_pkg::ctl_t                      ctl_i,
  input  wire logic [saabb_pkg::NUM_LANES-1:0][TF:0] quo_i,
  input  wire logic [saabb_pkg::NUM_LANES-1:0]      sat_i,
  output logic                                      vld_o,
  output logic                                      hit_o,
  output logic [TF:0]                               tf_o,
  output logic [TF:0]                               tl_o
);
  localparam logic [TF+1:0] T_ONE = (TF+2)'(1) << TF;
  localparam logic [TF+1:0] T_TWO = (TF+2)'(2) << TF;

  logic [saabb_pkg::NUM_LANES-1:0][TF+1:0] t;
  logic [TF+1:0] tf, tl;
  logic          hit_nxt;
  logic [TF:0]   tf_nxt, tl_nxt;
  logic          vld_r, hit_r;
  logic [TF:0]   tf_r, tl_r;

  always_comb begin
    for (int k = 0; k < saabb_pkg::NUM_LANES; k++) begin
      t[k] = sat_i[k] ? T_TWO : {1'b0, quo_i[k]};
    end
    tf = '0;
    tl = T_ONE;
    if (ctl_i.en[saabb_pkg::LANE_XF] && t[saabb_pkg::LANE_XF] > tf) begin
      tf = t[saabb_pkg::LANE_XF];
    end
    if (ctl_i.en[saabb_pkg::LANE_YF] && t[saabb_pkg::LANE_YF] > tf) begin
      tf = t[saabb_pkg::LANE_YF];
    end
    if (ctl_i.en[saabb_pkg::LANE_XL] && t[saabb_pkg::LANE_XL] < tl) begin
      tl = t[saabb_pkg::LANE_XL];
    end
    if (ctl_i.en[saabb_pkg::LANE_YL] && t[saabb_pkg::LANE_YL] < tl) begin
      tl = t[saabb_pkg::LANE_YL];
    end
    hit_nxt = 1'b0;
    tf_nxt  = '0;
    tl_nxt  = '0;
    if (ctl_i.overlap) begin
      hit_nxt = 1'b1;
    end else if (!ctl_i.miss && !(tf > tl)) begin
      hit_nxt = 1'b1;
      tf_nxt  = tf[TF:0];
      tl_nxt  = tl[TF:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_r <= hit_nxt;
      tf_r  <= tf_nxt;
      tl_r  <= tl_nxt;
    end
  end

  assign vld_o = vld_r;
  assign hit_o = hit_r;
  assign tf_o  = tf_r;
  assign tl_o  = tl_r;
endmodule
`default_nettype wire
